// ===== rtl/core/irac_pkg.sv =====
package irac_pkg;

  localparam int FRAME_BYTES = 28;
  localparam int FRAME_BITS  = FRAME_BYTES * 8;
  localparam int TOTAL_DUR   = FRAME_BYTES * 16 + 4;
  localparam int IDX_W       = 9;
  localparam int DUR_W       = 15;
  localparam int QUEUE_DEPTH = 2;

  // durations in microseconds
  localparam logic [DUR_W-1:0] HDR_MARK_US   = 15'd3300;
  localparam logic [DUR_W-1:0] HDR_SPACE_US  = 15'd1700;
  localparam logic [DUR_W-1:0] BIT_MARK_US   = 15'd400;
  localparam logic [DUR_W-1:0] ONE_SPACE_US  = 15'd1250;
  localparam logic [DUR_W-1:0] ZERO_SPACE_US = 15'd500;
  localparam logic [DUR_W-1:0] GAP_US        = 15'd30000;

  localparam logic [7:0] TEMP_MIN     = 8'd16;
  localparam logic [7:0] TEMP_MAX     = 8'd32;
  localparam logic [6:0] TEMP_FAN     = 7'd64;
  localparam logic [7:0] CSUM_BASE    = 8'd62;
  localparam logic [7:0] TLO_AT_MIN   = 8'h90;
  localparam logic [7:0] TLO_OTHER    = 8'h10;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  // settings mode codes
  localparam logic [2:0] MODE_AUTO = 3'd0;
  localparam logic [2:0] MODE_COOL = 3'd1;
  localparam logic [2:0] MODE_DRY  = 3'd2;
  localparam logic [2:0] MODE_HEAT = 3'd3;
  localparam logic [2:0] MODE_FAN  = 3'd4;

  // fan speed settings
  localparam logic [1:0] FAN_AUTO = 2'd0;
  localparam logic [1:0] FAN_LOW  = 2'd1;
  localparam logic [1:0] FAN_MED  = 2'd2;
  localparam logic [1:0] FAN_HIGH = 2'd3;

  // wire codes
  localparam logic [3:0] MCODE_AUTO = 4'h2;
  localparam logic [3:0] MCODE_COOL = 4'h4;
  localparam logic [3:0] MCODE_DRY  = 4'h5;
  localparam logic [3:0] MCODE_HEAT = 4'h3;
  localparam logic [3:0] MCODE_FAN  = 4'hC;
  localparam logic [2:0] FCODE_AUTO = 3'd1;
  localparam logic [2:0] FCODE_LOW  = 3'd2;
  localparam logic [2:0] FCODE_MED  = 3'd3;
  localparam logic [2:0] FCODE_HIGH = 3'd5;

  // byte positions that depend on the settings
  localparam int B_TEMP_LO = 9;
  localparam int B_MODE    = 10;
  localparam int B_TEMP    = 11;
  localparam int B_FAN     = 13;
  localparam int B_SWING   = 14;
  localparam int B_POWER   = 17;
  localparam int B_CSUM    = FRAME_BYTES - 1;

  localparam logic [7:0] TEMPLATE [FRAME_BYTES] = '{
    8'h80, 8'h08, 8'h0C, 8'h02, 8'hFD, 8'h80, 8'h7F, 8'h88,
    8'h48, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h60, 8'h60,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h80, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // sum of the reversed template bytes that no setting touches
  function automatic logic [7:0] fixed_rev_sum();
    logic [7:0] s;
    s = 8'd0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      if (i != B_TEMP_LO && i != B_MODE && i != B_TEMP && i != B_FAN &&
          i != B_SWING && i != B_POWER) begin
        s = s + bit_rev8(TEMPLATE[i]);
      end
    end
    return s;
  endfunction

  localparam logic [7:0] FIXED_SUM = fixed_rev_sum();

  // one classified beat as it sits in the queue
  typedef struct packed {
    logic       is_load;
    logic       power;
    logic       swing;
    logic [3:0] mcode;
    logic [7:0] tbyte;
    logic [2:0] fcode;
    logic       t16;
    logic [7:0] csum;
  } cmd_t;

endpackage

// ===== rtl/core/irac_front.sv =====
module irac_front (
  input  logic                opcode,
  input  logic                power_on,
  input  logic [2:0]          ac_mode,
  input  logic [1:0]          fan_speed,
  input  logic [7:0]          temp_celsius,
  input  logic                swing_on,
  output irac_pkg::cmd_t      cmd
);

  logic [3:0] mcode;
  logic [2:0] fcode;
  logic [7:0] tclamp;
  logic [6:0] tfield;
  logic [7:0] tbyte;
  logic       t16;
  logic [7:0] tlo_rev;
  logic [7:0] swing_rev;
  logic [7:0] power_rev;

  // mode wire code, unknown modes fall back to auto
  always_comb begin
    case (ac_mode)
      irac_pkg::MODE_COOL: mcode = irac_pkg::MCODE_COOL;
      irac_pkg::MODE_DRY:  mcode = irac_pkg::MCODE_DRY;
      irac_pkg::MODE_HEAT: mcode = irac_pkg::MCODE_HEAT;
      irac_pkg::MODE_FAN:  mcode = irac_pkg::MCODE_FAN;
      default:             mcode = irac_pkg::MCODE_AUTO;
    endcase
  end

  // fan wire code: dry forces low, fan mode turns auto into low
  always_comb begin
    if (mcode == irac_pkg::MCODE_DRY) begin
      fcode = irac_pkg::FCODE_LOW;
    end else begin
      case (fan_speed)
        irac_pkg::FAN_LOW:  fcode = irac_pkg::FCODE_LOW;
        irac_pkg::FAN_MED:  fcode = irac_pkg::FCODE_MED;
        irac_pkg::FAN_HIGH: fcode = irac_pkg::FCODE_HIGH;
        default: fcode = (mcode == irac_pkg::MCODE_FAN) ? irac_pkg::FCODE_LOW
                                                        : irac_pkg::FCODE_AUTO;
      endcase
    end
  end

  // temperature clamp and field
  always_comb begin
    if (temp_celsius < irac_pkg::TEMP_MIN) begin
      tclamp = irac_pkg::TEMP_MIN;
    end else if (temp_celsius > irac_pkg::TEMP_MAX) begin
      tclamp = irac_pkg::TEMP_MAX;
    end else begin
      tclamp = temp_celsius;
    end
  end

  assign tfield = (mcode == irac_pkg::MCODE_FAN) ? irac_pkg::TEMP_FAN : tclamp[6:0];
  assign tbyte  = {tfield, 1'b0};
  assign t16    = (tclamp == irac_pkg::TEMP_MIN);

  // reversed contributions of the setting-dependent bytes
  assign tlo_rev   = irac_pkg::bit_rev8(t16 ? irac_pkg::TLO_AT_MIN : irac_pkg::TLO_OTHER);
  assign swing_rev = irac_pkg::bit_rev8({swing_on, irac_pkg::TEMPLATE[irac_pkg::B_SWING][6:0]});
  assign power_rev = irac_pkg::bit_rev8({irac_pkg::TEMPLATE[irac_pkg::B_POWER][7:1], power_on});

  always_comb begin
    cmd.is_load = (opcode == irac_pkg::OP_LOAD);
    cmd.power   = power_on;
    cmd.swing   = swing_on;
    cmd.mcode   = mcode;
    cmd.tbyte   = tbyte;
    cmd.fcode   = fcode;
    cmd.t16     = t16;
    cmd.csum    = irac_pkg::CSUM_BASE - irac_pkg::FIXED_SUM - tlo_rev - {4'd0, mcode}
                  - tbyte - {5'd0, fcode} - swing_rev - power_rev;
  end

endmodule

// ===== rtl/core/irac_queue.sv =====
module irac_queue #(
  parameter int DEPTH = irac_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  irac_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output irac_pkg::cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  irac_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = slots[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/irac_back.sv =====
module irac_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  irac_pkg::cmd_t                head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [irac_pkg::DUR_W-1:0]    duration_us,
  output logic                          is_mark,
  output logic                          last
);

  localparam int FB = irac_pkg::FRAME_BYTES;
  localparam logic [irac_pkg::IDX_W-1:0] TOTAL = irac_pkg::IDX_W'(irac_pkg::TOTAL_DUR);
  localparam logic [irac_pkg::IDX_W-1:0] IDX_END_MARK = TOTAL - 2'd2;
  localparam logic [irac_pkg::IDX_W-1:0] IDX_GAP      = TOTAL - 2'd1;
  localparam logic [7:0] TOP_BIT = 8'(irac_pkg::FRAME_BITS - 1);

  // stored frame settings (payload)
  logic       power;
  logic       swing;
  logic [3:0] mcode;
  logic [7:0] tbyte;
  logic [2:0] fcode;
  logic       t16;
  logic [7:0] csum;

  // control
  logic                       active;
  logic [irac_pkg::IDX_W-1:0] idx;

  logic [irac_pkg::FRAME_BITS-1:0] frame_vec;
  logic [irac_pkg::IDX_W-1:0]      k;
  logic [7:0]                      bitno;
  logic                            frame_bit;
  logic                            has_result;
  logic                            slot_free;
  logic [irac_pkg::DUR_W-1:0]      dur_next;
  logic                            mark_next;
  logic                            last_next;

  // frame image: template with the setting bytes laid over it, byte 0 on top
  always_comb begin
    for (int i = 0; i < FB; i++) begin
      frame_vec[8*(FB-1-i) +: 8] = irac_pkg::TEMPLATE[i];
    end
    frame_vec[8*(FB-1-irac_pkg::B_TEMP_LO) +: 8] = t16 ? irac_pkg::TLO_AT_MIN
                                                       : irac_pkg::TLO_OTHER;
    frame_vec[8*(FB-1-irac_pkg::B_MODE) +: 8]  = irac_pkg::bit_rev8({4'd0, mcode});
    frame_vec[8*(FB-1-irac_pkg::B_TEMP) +: 8]  = irac_pkg::bit_rev8(tbyte);
    frame_vec[8*(FB-1-irac_pkg::B_FAN) +: 8]   = irac_pkg::bit_rev8({5'd0, fcode});
    // swing is bit 7 of its byte, power is bit 0 of its byte
    frame_vec[8*(FB-1-irac_pkg::B_SWING) + 7]  = swing;
    frame_vec[8*(FB-1-irac_pkg::B_POWER) +: 1] = power;
    frame_vec[8*(FB-1-irac_pkg::B_CSUM) +: 8]  = irac_pkg::bit_rev8(csum);
  end

  // bit select, MSB first
  assign k         = idx - 2'd2;
  assign bitno     = k[8:1];
  assign frame_bit = frame_vec[TOP_BIT - bitno];

  // duration selection
  always_comb begin
    last_next = 1'b0;
    if (idx == '0) begin
      dur_next  = irac_pkg::HDR_MARK_US;
      mark_next = 1'b1;
    end else if (idx == 9'd1) begin
      dur_next  = irac_pkg::HDR_SPACE_US;
      mark_next = 1'b0;
    end else if (idx == IDX_END_MARK) begin
      dur_next  = irac_pkg::BIT_MARK_US;
      mark_next = 1'b1;
    end else if (idx == IDX_GAP) begin
      dur_next  = irac_pkg::GAP_US;
      mark_next = 1'b0;
      last_next = 1'b1;
    end else if (!k[0]) begin
      dur_next  = irac_pkg::BIT_MARK_US;
      mark_next = 1'b1;
    end else begin
      dur_next  = frame_bit ? irac_pkg::ONE_SPACE_US : irac_pkg::ZERO_SPACE_US;
      mark_next = 1'b0;
    end
  end

  // a next beat needs the output slot only if it yields a duration
  assign has_result = !head.is_load && active && (idx < TOTAL);
  assign slot_free  = !out_valid || !out_stall;
  assign pop        = head_valid && (!has_result || slot_free);

  // frame settings capture on load
  always_ff @(posedge clk) begin
    if (pop && head.is_load) begin
      power <= head.power;
      swing <= head.swing;
      mcode <= head.mcode;
      tbyte <= head.tbyte;
      fcode <= head.fcode;
      t16   <= head.t16;
      csum  <= head.csum;
    end
  end

  // sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && has_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head.is_load) begin
          active <= 1'b1;
          idx    <= '0;
        end else if (!has_result) begin
          active <= 1'b0;
        end else begin
          idx         <= idx + 1'b1;
          duration_us <= dur_next;
          is_mark     <= mark_next;
          last        <= last_next;
          if (last_next) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/ir_ac_frame_pulse_encoder_unit.sv =====
// IR air-conditioner frame encoder, 28-byte pulse-distance format.
// Input channel (in_valid/in_stall): opcode 0 loads power, mode, fan,
// temperature and swing and restarts the frame; opcode 1 asks for the next
// duration. A load beat gives no result, nor does a next beat with no frame.
// Output channel (out_valid/out_stall): one duration per next beat, in us,
// with is_mark and last; a frame is header mark and space, 224 bits as a
// mark plus a short or long space, an end mark and a 30000 us gap (last).
// A result is registered: its beat is written into the queue when taken,
// and the output register loads the duration when the back end pops it.
// Throughput: one beat per cycle while the output is not stalled; the bit
// select and duration mux in the back end are combinational.
// A two-entry queue parts the front end from the back end; when the
// receiver stalls, the back end holds its output and the queue fills, then
// in_stall rises while the queue is full. Any load or no-result beat still
// drains from the queue while the output waits.
// Reset clears the queue and output valid and leaves no frame active; a
// next beat before the first load gives nothing.
module ir_ac_frame_pulse_encoder_unit #(
  parameter int QUEUE_DEPTH = irac_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       opcode,
  input  logic                       power_on,
  input  logic [2:0]                 ac_mode,
  input  logic [1:0]                 fan_speed,
  input  logic [7:0]                 temp_celsius,
  input  logic                       swing_on,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [irac_pkg::DUR_W-1:0] duration_us,
  output logic                       is_mark,
  output logic                       last
);

  irac_pkg::cmd_t in_cmd;
  irac_pkg::cmd_t head;
  logic           head_valid;
  logic           pop;
  logic           full;

  assign in_stall = full;

  irac_front u_front (
    .opcode       (opcode),
    .power_on     (power_on),
    .ac_mode      (ac_mode),
    .fan_speed    (fan_speed),
    .temp_celsius (temp_celsius),
    .swing_on     (swing_on),
    .cmd          (in_cmd)
  );

  irac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid),
    .push_data  (in_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  irac_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .duration_us (duration_us),
    .is_mark     (is_mark),
    .last        (last)
  );

endmodule
